// File: src/ttbr_pkg.sv
// package for the timed thermostat with blink readout: constants, types and digit helpers
package ttbr_pkg;

  localparam int unsigned TICKS_PER_SECOND   = 100;
  localparam int unsigned SECONDS_PER_MINUTE = 60;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TEMP_THRESHOLD = 3'd0,
    REG_OFF_MINUTE     = 3'd1,
    REG_CYCLE_MINUTE   = 3'd2,
    REG_BLINK_TICKS    = 3'd3,
    REG_SIGN_ON_TICKS  = 3'd4,
    REG_SIGN_OFF_TICKS = 3'd5,
    REG_DIGIT_PAUSE    = 3'd6,
    REG_END_PAUSE      = 3'd7
  } reg_index_t;

  localparam logic signed [7:0] TEMP_THRESHOLD_RST = 8'sd24;
  localparam logic [7:0]        OFF_MINUTE_RST     = 8'd10;
  localparam logic [7:0]        CYCLE_MINUTE_RST   = 8'd30;
  localparam logic [9:0]        BLINK_TICKS_RST    = 10'd35;
  localparam logic [9:0]        SIGN_ON_RST        = 10'd250;
  localparam logic [9:0]        SIGN_OFF_RST       = 10'd300;
  localparam logic [9:0]        DIGIT_PAUSE_RST    = 10'd200;
  localparam logic [9:0]        END_PAUSE_RST      = 10'd500;

  typedef enum logic [2:0] {
    PH_SIGN_ON  = 3'd0,
    PH_SIGN_OFF = 3'd1,
    PH_TENS_ON  = 3'd2,
    PH_TENS_OFF = 3'd3,
    PH_MID      = 3'd4,
    PH_ONES_ON  = 3'd5,
    PH_ONES_OFF = 3'd6,
    PH_END      = 3'd7
  } phase_t;

  typedef struct packed {
    logic       gas_on;
    logic       led_on;
    logic [7:0] minutes_elapsed;
  } result_t;

  // tens digit by reciprocal multiply, exact for values up to 127
  function automatic logic [3:0] tens_of(input logic [6:0] mag);
    logic [14:0] prod;
    prod = 15'(mag) * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [3:0] ones_of(input logic [6:0] mag);
    logic [3:0] tens;
    logic [6:0] tens_x10;
    logic [6:0] diff;
    tens     = tens_of(mag);
    tens_x10 = {tens, 3'b000} - 7'(tens) + 7'(tens) + {2'b00, tens, 1'b0};
    diff     = mag - tens_x10;
    return diff[3:0];
  endfunction

endpackage

// File: src/timed_thermostat_with_blink_readout_top.sv
// top level of the timed thermostat with blink readout
//
//  channel  handshake                     payload
//  in       in_valid / in_stall           temp_valid, temp_value
//  out      out_valid / out_stall         gas_on, led_on, minutes_elapsed
//  cfg      cfg_we                        cfg_index, cfg_data
//
// one tick transaction per cycle while in_stall is low; the result is registered into the output buffer on acceptance
// all counters, gas rule and readout sequencer update in the accepting cycle
// a two-entry output buffer keeps input flowing while one result waits
// in_stall rises only when both buffer entries are full
// synchronous reset restores default registers, gas on and an expired end pause
module timed_thermostat_with_blink_readout_top
  import ttbr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   temp_valid,
  input  logic signed [7:0]      temp_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   gas_on,
  output logic                   led_on,
  output logic [7:0]             minutes_elapsed
);

  // configuration registers
  logic signed [7:0] temp_threshold;
  logic [7:0]        off_minute;
  logic [7:0]        cycle_minute;
  logic [9:0]        blink_ticks;
  logic [9:0]        sign_on_ticks;
  logic [9:0]        sign_off_ticks;
  logic [9:0]        digit_pause_ticks;
  logic [9:0]        end_pause_ticks;

  // state
  logic [6:0]        tick_count, tick_count_next;
  logic [5:0]        second_count, second_count_next;
  logic [7:0]        minute_count, minute_count_next;
  logic              gas_state, gas_state_next;
  logic signed [7:0] held_temperature, held_temperature_next;
  logic [6:0]        shown_magnitude, shown_magnitude_next;
  phase_t            readout_phase, readout_phase_next;
  logic [9:0]        phase_timer, phase_timer_next;
  logic [3:0]        blinks_left, blinks_left_next;

  // output buffer
  result_t           slot0, slot1, result_next;
  logic [1:0]        fill;
  logic              push, pop;

  // combinational helpers
  logic [6:0]        tick_inc;
  logic [5:0]        second_inc;
  logic [7:0]        minute_inc;
  logic [6:0]        new_magnitude;
  logic [6:0]        digit_src;
  logic [3:0]        tens_digit, ones_digit;
  logic [3:0]        blinks_dec;
  logic [9:0]        phase_len, phase_len_eff;
  logic [7:0]        neg_temp;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_threshold    <= TEMP_THRESHOLD_RST;
      off_minute        <= OFF_MINUTE_RST;
      cycle_minute      <= CYCLE_MINUTE_RST;
      blink_ticks       <= BLINK_TICKS_RST;
      sign_on_ticks     <= SIGN_ON_RST;
      sign_off_ticks    <= SIGN_OFF_RST;
      digit_pause_ticks <= DIGIT_PAUSE_RST;
      end_pause_ticks   <= END_PAUSE_RST;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_TEMP_THRESHOLD: temp_threshold    <= signed'(cfg_data[7:0]);
        REG_OFF_MINUTE:     off_minute        <= cfg_data[7:0];
        REG_CYCLE_MINUTE:   cycle_minute      <= cfg_data[7:0];
        REG_BLINK_TICKS:    blink_ticks       <= cfg_data;
        REG_SIGN_ON_TICKS:  sign_on_ticks     <= cfg_data;
        REG_SIGN_OFF_TICKS: sign_off_ticks    <= cfg_data;
        REG_DIGIT_PAUSE:    digit_pause_ticks <= cfg_data;
        REG_END_PAUSE:      end_pause_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign push = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;

  // timekeeping and gas rule
  always_comb begin
    held_temperature_next = temp_valid ? temp_value : held_temperature;

    tick_inc          = tick_count + 7'd1;
    second_inc        = second_count + 6'd1;
    minute_inc        = minute_count;
    tick_count_next   = tick_inc;
    second_count_next = second_count;
    if (tick_inc > 7'(TICKS_PER_SECOND - 1)) begin
      tick_count_next   = '0;
      second_count_next = second_inc;
      if (second_inc > 6'(SECONDS_PER_MINUTE - 1)) begin
        second_count_next = '0;
        minute_inc        = minute_count + 8'd1;
      end
    end

    minute_count_next = minute_inc;
    gas_state_next    = gas_state;
    if (minute_inc == off_minute || held_temperature_next >= temp_threshold) begin
      gas_state_next = 1'b0;
    end
    if (minute_inc >= cycle_minute && held_temperature_next < temp_threshold) begin
      gas_state_next    = 1'b1;
      minute_count_next = '0;
    end
  end

  // readout sequencer
  always_comb begin
    neg_temp = 8'd0 - 8'(held_temperature_next);
    if (held_temperature_next[7]) begin
      new_magnitude = neg_temp[7] ? 7'd127 : neg_temp[6:0];
    end else begin
      new_magnitude = held_temperature_next[6:0];
    end
    digit_src  = (readout_phase == PH_END) ? new_magnitude : shown_magnitude;
    tens_digit = tens_of(digit_src);
    ones_digit = ones_of(digit_src);
    blinks_dec = blinks_left - 4'd1;

    readout_phase_next   = readout_phase;
    shown_magnitude_next = shown_magnitude;
    blinks_left_next     = blinks_left;
    phase_len            = '0;

    if (phase_timer == '0) begin
      unique case (readout_phase)
        PH_SIGN_ON: begin
          readout_phase_next = PH_SIGN_OFF;
          phase_len          = sign_off_ticks;
        end
        PH_SIGN_OFF, PH_END: begin
          if (readout_phase == PH_END) begin
            shown_magnitude_next = new_magnitude;
          end
          if (readout_phase == PH_END && held_temperature_next[7]) begin
            readout_phase_next = PH_SIGN_ON;
            phase_len          = sign_on_ticks;
          end else begin
            blinks_left_next = tens_digit;
            if (tens_digit != '0) begin
              readout_phase_next = PH_TENS_ON;
              phase_len          = blink_ticks;
            end else begin
              readout_phase_next = PH_MID;
              phase_len          = digit_pause_ticks;
            end
          end
        end
        PH_TENS_ON: begin
          readout_phase_next = PH_TENS_OFF;
          phase_len          = blink_ticks;
        end
        PH_TENS_OFF: begin
          blinks_left_next = blinks_dec;
          if (blinks_dec != '0) begin
            readout_phase_next = PH_TENS_ON;
            phase_len          = blink_ticks;
          end else begin
            readout_phase_next = PH_MID;
            phase_len          = digit_pause_ticks;
          end
        end
        PH_MID: begin
          blinks_left_next = ones_digit;
          if (ones_digit != '0) begin
            readout_phase_next = PH_ONES_ON;
            phase_len          = blink_ticks;
          end else begin
            readout_phase_next = PH_END;
            phase_len          = end_pause_ticks;
          end
        end
        PH_ONES_ON: begin
          readout_phase_next = PH_ONES_OFF;
          phase_len          = blink_ticks;
        end
        PH_ONES_OFF: begin
          blinks_left_next = blinks_dec;
          if (blinks_dec != '0) begin
            readout_phase_next = PH_ONES_ON;
            phase_len          = blink_ticks;
          end else begin
            readout_phase_next = PH_END;
            phase_len          = end_pause_ticks;
          end
        end
        default: ;
      endcase
      phase_len_eff    = (phase_len == '0) ? 10'd1 : phase_len;
      phase_timer_next = phase_len_eff - 10'd1;
    end else begin
      phase_len_eff    = phase_timer;
      phase_timer_next = phase_timer - 10'd1;
    end

    result_next.gas_on          = gas_state_next;
    result_next.led_on          = (readout_phase_next == PH_SIGN_ON) ||
                                  (readout_phase_next == PH_TENS_ON) ||
                                  (readout_phase_next == PH_ONES_ON);
    result_next.minutes_elapsed = minute_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count       <= '0;
      second_count     <= '0;
      minute_count     <= '0;
      gas_state        <= 1'b1;
      held_temperature <= '0;
      shown_magnitude  <= '0;
      readout_phase    <= PH_END;
      phase_timer      <= '0;
      blinks_left      <= '0;
    end else if (push) begin
      tick_count       <= tick_count_next;
      second_count     <= second_count_next;
      minute_count     <= minute_count_next;
      gas_state        <= gas_state_next;
      held_temperature <= held_temperature_next;
      shown_magnitude  <= shown_magnitude_next;
      readout_phase    <= readout_phase_next;
      phase_timer      <= phase_timer_next;
      blinks_left      <= blinks_left_next;
    end
  end

  // two-entry result buffer, slot0 faces the output
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      priority case (1'b1)
        push && !pop: fill <= fill + 2'd1;
        pop && !push: fill <= fill - 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fill == 2'd2) begin
      if (pop) begin
        slot0 <= slot1;
      end
    end else if (fill == 2'd1) begin
      if (push && pop) begin
        slot0 <= result_next;
      end else if (push) begin
        slot1 <= result_next;
      end
    end else if (push) begin
      slot0 <= result_next;
    end
  end

  assign in_stall        = (fill == 2'd2);
  assign out_valid       = (fill != 2'd0);
  assign gas_on          = slot0.gas_on;
  assign led_on          = slot0.led_on;
  assign minutes_elapsed = slot0.minutes_elapsed;

endmodule

// File: sim/tb_top.sv
// testbench for the timed thermostat with blink readout: tick stimulus, readout prediction and checks
module tb_top;
  import ttbr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 200;
  localparam int PRINT_LIMIT    = 40;

  typedef struct packed {
    logic              fresh;
    logic signed [7:0] reading;
  } tick_t;

  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              cfg_we      = 1'b0;
  reg_index_t        cfg_index   = REG_TEMP_THRESHOLD;
  logic [9:0]        cfg_data    = '0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic              temp_valid  = 1'b0;
  logic signed [7:0] temp_value  = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic              gas_on;
  logic              led_on;
  logic [7:0]        minutes_elapsed;

  timed_thermostat_with_blink_readout_top dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .temp_valid      (temp_valid),
    .temp_value      (temp_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .gas_on          (gas_on),
    .led_on          (led_on),
    .minutes_elapsed (minutes_elapsed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow
  logic signed [7:0] thr_reg;
  logic [7:0]        off_reg;
  logic [7:0]        cycle_reg;
  logic [9:0]        blink_reg;
  logic [9:0]        sign_on_reg;
  logic [9:0]        sign_off_reg;
  logic [9:0]        mid_reg;
  logic [9:0]        end_reg;

  // thermostat and readout state
  logic [6:0]        ticks;
  logic [5:0]        secs;
  logic [7:0]        mins;
  logic              gas;
  logic signed [7:0] held;
  logic [6:0]        magnitude;
  phase_t            phase;
  logic [9:0]        timer;
  logic [3:0]        blinks;

  tick_t   pending_ticks[$];
  result_t due_readouts[$];
  result_t predicted;
  result_t wanted;

  logic fast_mode   = 1'b0;
  int   hold_asked  = 0;
  int   hold_served = 0;
  int   send_wait   = 0;
  int   stall_left  = 0;
  int   next_stall;
  int   quiet_cycles = 0;
  int   mismatches   = 0;
  int   readout_count = 0;
  int   queued_count  = 0;
  tick_t next_tick;

  function automatic void reset_thermostat();
    thr_reg = TEMP_THRESHOLD_RST;
    off_reg = OFF_MINUTE_RST;
    cycle_reg = CYCLE_MINUTE_RST;
    blink_reg = BLINK_TICKS_RST;
    sign_on_reg = SIGN_ON_RST;
    sign_off_reg = SIGN_OFF_RST;
    mid_reg = DIGIT_PAUSE_RST;
    end_reg = END_PAUSE_RST;
    ticks = '0;
    secs = '0;
    mins = '0;
    gas = 1'b1;
    held = '0;
    magnitude = '0;
    phase = PH_END;
    timer = '0;
    blinks = '0;
  endfunction

  function automatic void load_phase(phase_t p, logic [9:0] len);
    phase = p;
    timer = (len == 10'd0) ? 10'd1 : len;
  endfunction

  function automatic void start_digit(logic [3:0] count, phase_t on_ph, phase_t after_ph,
                                      logic [9:0] after_len);
    blinks = count;
    if (count != 4'd0) load_phase(on_ph, blink_reg);
    else load_phase(after_ph, after_len);
  endfunction

  function automatic void next_readout_phase();
    case (phase)
      PH_SIGN_ON:  load_phase(PH_SIGN_OFF, sign_off_reg);
      PH_SIGN_OFF: start_digit(4'(magnitude / 7'd10), PH_TENS_ON, PH_MID, mid_reg);
      PH_TENS_ON:  load_phase(PH_TENS_OFF, blink_reg);
      PH_TENS_OFF: start_digit(blinks - 4'd1, PH_TENS_ON, PH_MID, mid_reg);
      PH_MID:      start_digit(4'(magnitude % 7'd10), PH_ONES_ON, PH_END, end_reg);
      PH_ONES_ON:  load_phase(PH_ONES_OFF, blink_reg);
      PH_ONES_OFF: start_digit(blinks - 4'd1, PH_ONES_ON, PH_END, end_reg);
      default: begin
        if (held < 0) begin
          magnitude = (held == 8'sh80) ? 7'd127 : 7'(-held);
          load_phase(PH_SIGN_ON, sign_on_reg);
        end else begin
          magnitude = 7'(held);
          start_digit(4'(magnitude / 7'd10), PH_TENS_ON, PH_MID, mid_reg);
        end
      end
    endcase
  endfunction

  function automatic result_t advance_tick(logic fresh, logic signed [7:0] reading);
    result_t r;
    if (fresh) held = reading;
    ticks = ticks + 7'd1;
    if (ticks > TICKS_PER_SECOND - 1) begin
      ticks = '0;
      secs = secs + 6'd1;
      if (secs > SECONDS_PER_MINUTE - 1) begin
        secs = '0;
        mins = mins + 8'd1;
      end
    end
    if (mins == off_reg || held >= thr_reg) gas = 1'b0;
    if (mins >= cycle_reg && held < thr_reg) begin
      gas = 1'b1;
      mins = '0;
    end
    if (timer == 10'd0) next_readout_phase();
    timer = timer - 10'd1;
    r.gas_on = gas;
    r.led_on = (phase == PH_SIGN_ON) || (phase == PH_TENS_ON) || (phase == PH_ONES_ON);
    r.minutes_elapsed = mins;
    return r;
  endfunction

  function automatic int draw_wait();
    if (fast_mode || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic logic signed [7:0] pick_reading();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'($urandom);
    if (r == 1) return $urandom_range(0, 1) ? 8'sh7F : 8'sh80;
    return 8'($urandom_range(0, 180) - 55);
  endfunction

  function automatic logic [9:0] pick_length();
    case ($urandom_range(0, 7))
      0: return 10'd0;
      1: return 10'($urandom);
      default: return 10'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [7:0] pick_minute();
    return $urandom_range(0, 1) ? 8'($urandom_range(0, 2)) : 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return 8'h80;
      1: return 8'h7F;
      default: return 8'($urandom_range(0, 180) - 55);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("mismatch on readout %0d: %s", readout_count, what);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [9:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_TEMP_THRESHOLD: thr_reg = data[7:0];
      REG_OFF_MINUTE:     off_reg = data[7:0];
      REG_CYCLE_MINUTE:   cycle_reg = data[7:0];
      REG_BLINK_TICKS:    blink_reg = data;
      REG_SIGN_ON_TICKS:  sign_on_reg = data;
      REG_SIGN_OFF_TICKS: sign_off_reg = data;
      REG_DIGIT_PAUSE:    mid_reg = data;
      default:            end_reg = data;
    endcase
  endtask

  task automatic apply_setting(input logic [7:0] thr, input logic [7:0] off_m,
                               input logic [7:0] cyc, input logic [9:0] blink,
                               input logic [9:0] son, input logic [9:0] soff,
                               input logic [9:0] mid, input logic [9:0] endp);
    write_reg(REG_TEMP_THRESHOLD, {2'($urandom), thr});
    write_reg(REG_OFF_MINUTE, {2'($urandom), off_m});
    write_reg(REG_CYCLE_MINUTE, {2'($urandom), cyc});
    write_reg(REG_BLINK_TICKS, blink);
    write_reg(REG_SIGN_ON_TICKS, son);
    write_reg(REG_SIGN_OFF_TICKS, soff);
    write_reg(REG_DIGIT_PAUSE, mid);
    write_reg(REG_END_PAUSE, endp);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_tick(input logic fresh, input logic signed [7:0] reading);
    tick_t t;
    t.fresh = fresh;
    t.reading = reading;
    pending_ticks.push_back(t);
    queued_count++;
  endtask

  task automatic queue_random_ticks(input int count, input int fresh_pct);
    for (int i = 0; i < count; i++)
      queue_tick($urandom_range(0, 99) < fresh_pct, pick_reading());
  endtask

  task automatic wait_quiet();
    @(posedge clk);
    while (readout_count != queued_count) @(posedge clk);
  endtask

  // tick sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (send_wait != 0) begin
        send_wait <= send_wait - 1;
        in_valid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        next_tick = pending_ticks.pop_front();
        in_valid <= 1'b1;
        temp_valid <= next_tick.fresh;
        temp_value <= next_tick.reading;
        send_wait <= draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // readout receiver
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else begin
      if (hold_served != hold_asked) begin
        next_stall = LONG_HOLD;
        hold_served <= hold_asked;
      end else if (out_valid && !out_stall) begin
        next_stall = draw_wait();
      end else if (stall_left != 0) begin
        next_stall = stall_left - 1;
      end else begin
        next_stall = 0;
      end
      stall_left <= next_stall;
      out_stall <= (next_stall != 0);
    end
  end

  // prediction on each accepted tick, check on each accepted readout
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predicted = advance_tick(temp_valid, temp_value);
        due_readouts.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        readout_count++;
        if (due_readouts.size() == 0) begin
          report_mismatch("readout with no tick waiting");
        end else begin
          wanted = due_readouts.pop_front();
          if (gas_on !== wanted.gas_on)
            report_mismatch($sformatf("gas_on %b, expected %b", gas_on, wanted.gas_on));
          if (led_on !== wanted.led_on)
            report_mismatch($sformatf("led_on %b, expected %b", led_on, wanted.led_on));
          if (minutes_elapsed !== wanted.minutes_elapsed)
            report_mismatch($sformatf("minutes_elapsed %0d, expected %0d",
                                      minutes_elapsed, wanted.minutes_elapsed));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_thermostat();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings, first tick starts a sequence
    queue_tick(1'b1, 8'sh7F);
    queue_tick(1'b0, 8'sh80);
    queue_tick(1'b1, 8'sh80);
    queue_tick(1'b1, 8'sh00);
    queue_tick(1'b1, -8'sd1);
    queue_tick(1'b0, 8'sh00);
    wait_quiet();

    // zero lengths act as one tick, minute rules at zero
    apply_setting(8'd10, 8'd0, 8'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
    queue_tick(1'b1, 8'sd9);
    queue_tick(1'b1, 8'sd10);
    queue_tick(1'b1, -8'sd1);
    queue_tick(1'b1, 8'sd0);
    queue_tick(1'b1, 8'sh80);
    queue_tick(1'b1, 8'sh7F);
    queue_tick(1'b1, 8'sd99);
    queue_tick(1'b1, 8'sd100);
    queue_tick(1'b1, -8'sd55);
    queue_tick(1'b1, 8'sd125);
    queue_tick(1'b1, 8'sd11);
    queue_tick(1'b1, -8'sd10);
    queue_tick(1'b1, 8'sd1);
    queue_tick(1'b1, -8'sd9);
    queue_tick(1'b0, 8'sd50);
    queue_tick(1'b1, 8'sd24);
    wait_quiet();

    for (int k = 0; k < 8; k++) begin
      if (k == 0)
        apply_setting(8'h7F, 8'hFF, 8'hFF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
      else if (k == 1)
        apply_setting(8'h80, 8'h00, 8'h00, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1);
      else
        apply_setting(pick_threshold(), pick_minute(), pick_minute(), pick_length(),
                      pick_length(), pick_length(), pick_length(), pick_length());
      queue_random_ticks(150, $urandom_range(3, 60));
      wait_quiet();
    end

    // back-to-back ticks with one long receiver hold
    apply_setting(8'h7F, 8'd1, 8'd2, 10'd3, 10'd3, 10'd3, 10'd3, 10'd3);
    fast_mode <= 1'b1;
    hold_asked <= hold_asked + 1;
    queue_random_ticks(228, 1);
    wait_quiet();
    fast_mode <= 1'b0;

    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
